// ----- rtl/lmfb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame buffer package
// Command codes, command and word types, and the bit reverse helper.
// ----------------------------------------------------------------------------
package lmfb_pkg;

	localparam logic [3:0] MODE_COLUMN = 4'd0;
	localparam logic [3:0] MODE_ROW    = 4'd1;
	localparam logic [3:0] MODE_DOT    = 4'd2;
	localparam logic [3:0] MODE_LEFT   = 4'd3;
	localparam logic [3:0] MODE_RIGHT  = 4'd4;
	localparam logic [3:0] MODE_UP     = 4'd5;
	localparam logic [3:0] MODE_DOWN   = 4'd6;
	localparam logic [3:0] MODE_CLEAR  = 4'd7;
	localparam logic [3:0] MODE_REG    = 4'd8;
	localparam logic [3:0] MODE_ORIENT = 4'd9;

	localparam int TILE = 8;

	// one input beat as it travels through the command queue
	typedef struct packed {
		logic [3:0] mode;
		logic [4:0] column;
		logic [1:0] module_req;
		logic [2:0] row;
		logic [7:0] value;
		logic       rotate;
		logic       fill_zero;
		logic [1:0] new_orientation;
		logic [3:0] register_address;
		logic       reject;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic       word_valid;
		logic [1:0] module_slot;
		logic [3:0] word_address;
		logic [7:0] word_data;
		logic       end_of_frame;
		logic       rejected;
		logic       last;
	} word_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		r = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
		r = ((r & 8'hCC) >> 2) | ((r & 8'h33) << 2);
		r = ((r & 8'hAA) >> 1) | ((r & 8'h55) << 1);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lmfb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix front end
// Takes command beats, checks operands and queues them for the engine.
// ----------------------------------------------------------------------------
module lmfb_front import lmfb_pkg::*; #(
	parameter int MODULES = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  cmd_t       in_cmd,
	output logic       q_valid,
	input  wire        q_ready,
	output cmd_t       q_cmd
);
	localparam int NCOLS = MODULES * TILE;

	cmd_t q_mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t cls;
	logic push, pop;

	// classify: flag out of range operands and unknown modes
	always_comb begin
		cls = in_cmd;
		cls.reject = 1'b0;
		case (in_cmd.mode)
			MODE_COLUMN, MODE_DOT: cls.reject = (32'(in_cmd.column) >= NCOLS);
			MODE_ROW:              cls.reject = (32'(in_cmd.module_req) >= MODULES);
			MODE_LEFT, MODE_RIGHT, MODE_UP, MODE_DOWN,
			MODE_CLEAR, MODE_REG, MODE_ORIENT: cls.reject = 1'b0;
			default:               cls.reject = 1'b1;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = q_mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;

	// two entry queue
	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/lmfb_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix engine
// Holds the column buffer and orientation, executes one command at a time
// and emits driver word beats through an output register.
// ----------------------------------------------------------------------------
module lmfb_engine import lmfb_pkg::*; #(
	parameter int MODULES = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        q_valid,
	output logic       q_ready,
	input  cmd_t       q_cmd,
	output logic       out_valid,
	input  wire        out_ready,
	output word_t      out_word
);
	localparam int NCOLS = MODULES * TILE;
	localparam int CW = (NCOLS > 1) ? $clog2(NCOLS) : 1;
	localparam int SW = (MODULES > 1) ? $clog2(MODULES) : 1;
	localparam logic [CW-1:0] LASTC = CW'(NCOLS - 1);
	localparam logic [SW-1:0] LASTS = SW'(MODULES - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_UPDATE = 3'd1; // buffer-wide update
	localparam logic [2:0] ST_ROTATE = 3'd2; // tile rotate, one column a cycle
	localparam logic [2:0] ST_EMIT   = 3'd3; // word stream
	localparam logic [2:0] ST_ROWUPD = 3'd4; // row write: update one column

	// emit kinds
	localparam logic [2:0] EK_COL    = 3'd0; // single column frame
	localparam logic [2:0] EK_RELOAD = 3'd1;
	localparam logic [2:0] EK_CLEAR  = 3'd2;
	localparam logic [2:0] EK_REG    = 3'd3;
	localparam logic [2:0] EK_STATUS = 3'd4;
	localparam logic [2:0] EK_ROW    = 3'd5;

	logic [7:0]    fb_q   [NCOLS];
	logic [7:0]    nb_q   [NCOLS];
	logic [1:0]    orient_q;
	logic [2:0]    st_q, kind_q;
	cmd_t          cmd_q;
	logic [SW-1:0] cmod_q;
	logic [CW-1:0] idx_q;    // sweep index / target column
	logic [2:0]    fr_q;     // frame counter
	logic [SW-1:0] sl_q;     // slot counter
	logic [2:0]    bit_q;    // row bit for row writes
	logic [7:0]    val_q;
	logic [1:0]    delta_q;
	logic          ovalid_q;
	word_t         oword_q;

	assign q_ready   = (st_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_word  = oword_q;

	logic       oslot_free;
	assign oslot_free = !ovalid_q || out_ready;

	// oriented column write decode, on the queued command
	logic [7:0] dot_col;
	logic [7:0] cval;
	logic [CW-1:0] ccol;
	logic [SW-1:0] cmod;
	logic [2:0]    cmc;
	always_comb begin
		ccol = q_cmd.column[CW-1:0];
		cmod = SW'(q_cmd.column >> 3);
		cmc  = q_cmd.column[2:0];
		dot_col = fb_q[ccol];
		dot_col[q_cmd.row] = q_cmd.value[0];
		cval = (q_cmd.mode == MODE_DOT) ? dot_col : q_cmd.value;
	end

	// current beat fields during emission
	word_t       nw;
	logic [CW-1:0] rcol;
	logic          fin;
	always_comb begin
		rcol = CW'({sl_q, 3'b000}) | CW'(fr_q);
		nw = '0;
		nw.word_valid   = 1'b1;
		nw.module_slot  = 2'(sl_q);
		nw.end_of_frame = (sl_q == LASTS);
		fin = 1'b0;
		case (kind_q)
			EK_COL, EK_ROW: begin
				if (sl_q == SW'(idx_q >> 3)) begin
					nw.word_address = {1'b0, idx_q[2:0]} + 4'd1;
					// row frames send the column just updated in the buffer
					nw.word_data    = (kind_q == EK_ROW) ? fb_q[idx_q] : val_q;
				end
				fin = (sl_q == LASTS) && (kind_q == EK_COL || fr_q == 3'd7);
			end
			EK_RELOAD: begin
				nw.word_address = {1'b0, fr_q} + 4'd1;
				nw.word_data    = fb_q[rcol];
				fin = (sl_q == LASTS) && (fr_q == 3'd7);
			end
			EK_CLEAR: begin
				nw.word_address = {1'b0, fr_q} + 4'd1;
				fin = (sl_q == LASTS) && (fr_q == 3'd7);
			end
			EK_REG: begin
				nw.word_address = cmd_q.register_address;
				nw.word_data    = cmd_q.value;
				fin = (sl_q == LASTS);
			end
			default: begin
				nw = '0;
				nw.rejected = cmd_q.reject;
				fin = 1'b1;
			end
		endcase
		nw.last = fin;
	end

	// row write target column and new value for this frame
	logic [CW-1:0] rw_col;
	logic [7:0]    rw_val;
	always_comb begin
		rw_col = CW'({cmd_q.module_req, 3'b000}) | CW'(fr_q);
		if (cmd_q.mode == MODE_COLUMN || cmd_q.mode == MODE_DOT)
			rw_col = CW'({cmod_q, 3'b000}) | CW'(fr_q);
		rw_val = fb_q[rw_col];
		rw_val[bit_q] = val_q[3'd7 - fr_q];
	end

	// tile rotate: column idx of new buffer from old tile
	logic [7:0] rot_col;
	logic [CW-1:0] rbase;
	logic [2:0] nc;
	always_comb begin
		rbase = idx_q & ~CW'(7);
		nc = idx_q[2:0];
		rot_col = '0;
		for (int r = 0; r < 8; r++) begin
			case (delta_q)
				2'd1: rot_col[r] = fb_q[rbase | CW'(r)][3'd7 - nc];
				2'd2: rot_col[r] = fb_q[rbase | CW'(3'd7 - nc)][3'd7 - 3'(r)];
				default: rot_col[r] = fb_q[rbase | CW'(3'd7 - 3'(r))][nc];
			endcase
		end
	end

	// buffer and command datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOLS; i++) begin
				fb_q[i] <= 8'd0;
				nb_q[i] <= 8'd0;
			end
			cmd_q <= '0; cmod_q <= '0; idx_q <= '0; bit_q <= '0;
			val_q <= '0; delta_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (q_valid) begin
					cmd_q <= q_cmd;
					cmod_q <= cmod;
					if (!q_cmd.reject) begin
						case (q_cmd.mode)
							MODE_COLUMN, MODE_DOT: begin
								if (q_cmd.mode == MODE_DOT) fb_q[ccol] <= dot_col;
								case (orient_q)
									2'd0: begin
										idx_q <= ccol;
										val_q <= cval;
									end
									2'd1: begin
										bit_q <= cmc;
										val_q <= cval;
									end
									2'd2: begin
										idx_q <= LASTC - ccol;
										val_q <= rev8(cval);
									end
									default: begin
										bit_q <= 3'd7 - cmc;
										val_q <= rev8(cval);
									end
								endcase
							end
							MODE_ROW: begin
								val_q <= (orient_q[1]) ? rev8(q_cmd.value) : q_cmd.value;
								bit_q <= orient_q[1] ? 3'd7 - q_cmd.row : q_cmd.row;
								idx_q <= CW'({q_cmd.module_req, 3'b000}) |
									CW'(orient_q[1] ? 3'd7 - q_cmd.row : q_cmd.row);
							end
							MODE_ORIENT: begin
								delta_q <= q_cmd.new_orientation - orient_q;
								idx_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_UPDATE: begin
					case (cmd_q.mode)
						MODE_LEFT: begin
							for (int i = 0; i < NCOLS - 1; i++) fb_q[i] <= fb_q[i + 1];
							if (cmd_q.rotate) fb_q[NCOLS-1] <= fb_q[0];
							else if (cmd_q.fill_zero) fb_q[NCOLS-1] <= 8'd0;
						end
						MODE_RIGHT: begin
							for (int i = 1; i < NCOLS; i++) fb_q[i] <= fb_q[i - 1];
							if (cmd_q.rotate) fb_q[0] <= fb_q[NCOLS-1];
							else if (cmd_q.fill_zero) fb_q[0] <= 8'd0;
						end
						MODE_UP: if (orient_q == 2'd0)
							for (int i = 0; i < NCOLS; i++)
								fb_q[i] <= {cmd_q.rotate & fb_q[i][0], fb_q[i][7:1]};
						MODE_DOWN:
							for (int i = 0; i < NCOLS; i++)
								fb_q[i] <= {fb_q[i][6:0], cmd_q.rotate & fb_q[i][7]};
						MODE_CLEAR:
							for (int i = 0; i < NCOLS; i++) fb_q[i] <= 8'd0;
						default: ;
					endcase
				end
				ST_ROTATE: begin
					nb_q[idx_q] <= rot_col;
					if (idx_q == LASTC)
						for (int i = 0; i < NCOLS - 1; i++) fb_q[i] <= nb_q[i];
					if (idx_q == LASTC) fb_q[NCOLS-1] <= rot_col;
					else idx_q <= idx_q + CW'(1);
				end
				ST_ROWUPD: begin
					fb_q[rw_col] <= rw_val;
					idx_q <= rw_col;
				end
				ST_EMIT: if (oslot_free && kind_q == EK_COL && sl_q == LASTS)
					fb_q[idx_q] <= val_q;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; kind_q <= EK_STATUS; orient_q <= 2'd0;
			fr_q <= '0; sl_q <= '0; ovalid_q <= 1'b0; oword_q <= '0;
		end else begin
			if (ovalid_q && out_ready && st_q != ST_EMIT) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (q_valid) begin
					fr_q <= '0; sl_q <= '0; st_q <= ST_EMIT;
					if (q_cmd.reject) kind_q <= EK_STATUS;
					else begin
						case (q_cmd.mode)
							MODE_COLUMN, MODE_DOT: begin
								kind_q <= orient_q[0] ? EK_ROW : EK_COL;
								if (orient_q[0]) st_q <= ST_ROWUPD;
							end
							MODE_ROW: begin
								kind_q <= orient_q[0] ? EK_COL : EK_ROW;
								if (!orient_q[0]) st_q <= ST_ROWUPD;
							end
							MODE_LEFT, MODE_RIGHT, MODE_UP, MODE_DOWN: begin
								kind_q <= EK_RELOAD; st_q <= ST_UPDATE;
							end
							MODE_CLEAR: begin
								kind_q <= EK_CLEAR; st_q <= ST_UPDATE;
							end
							MODE_REG: kind_q <= EK_REG;
							default: begin
								if (q_cmd.new_orientation == orient_q) kind_q <= EK_STATUS;
								else begin
									kind_q <= EK_RELOAD; st_q <= ST_ROTATE;
									orient_q <= q_cmd.new_orientation;
								end
							end
						endcase
					end
				end
				ST_UPDATE: st_q <= ST_EMIT;
				ST_ROTATE: if (idx_q == LASTC) st_q <= ST_EMIT;
				ST_ROWUPD: st_q <= ST_EMIT;
				ST_EMIT: if (oslot_free) begin
					ovalid_q <= 1'b1;
					oword_q  <= nw;
					if (nw.last) st_q <= ST_IDLE;
					else if (sl_q == LASTS) begin
						sl_q <= '0;
						fr_q <= fr_q + 3'd1;
						if (kind_q == EK_ROW) st_q <= ST_ROWUPD;
					end else sl_q <= sl_q + SW'(1);
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/led_matrix_frame_buffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame buffer
// Column buffer and orientation for chained 8x8 LED driver modules.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries commands, m_axis carries result beats (driver words or a
//  single status beat); tlast marks the final beat of a command.
//  A front end checks operands and queues up to two commands; the engine
//  runs one command at a time.
//  After accept the engine first runs the buffer update, the tile rotate
//  sweep for an orientation change or a column update, then emits beats
//  through the output register, one beat per cycle while the receiver is
//  ready; a row write updates one column before each frame.
//  Reset clears the buffer to zero, sets the orientation to zero degrees
//  and empties all queues.
//  When the receiver stalls, the output register holds its beat and the
//  engine waits; the queue keeps taking commands until full.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer import lmfb_pkg::*; #(
	parameter int MODULES = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[3:0], column[8:4], module_req[10:9], row[13:11], value[21:14],
	// rotate[22], fill_zero[23], new_orientation[25:24],
	// register_address[29:26], zero fill to 32
	input  wire  [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// word_valid[0], module_slot[2:1], word_address[6:3], word_data[14:7],
	// end_of_frame[15]
	output logic [15:0] m_axis_tdata,
	// rejected[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);
	cmd_t  in_cmd, q_cmd;
	word_t ow;
	logic  q_valid, q_ready;

	always_comb begin
		in_cmd = '0;
		in_cmd.mode             = s_axis_tdata[3:0];
		in_cmd.column           = s_axis_tdata[8:4];
		in_cmd.module_req       = s_axis_tdata[10:9];
		in_cmd.row              = s_axis_tdata[13:11];
		in_cmd.value            = s_axis_tdata[21:14];
		in_cmd.rotate           = s_axis_tdata[22];
		in_cmd.fill_zero        = s_axis_tdata[23];
		in_cmd.new_orientation  = s_axis_tdata[25:24];
		in_cmd.register_address = s_axis_tdata[29:26];
	end

	lmfb_front #(.MODULES(MODULES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	lmfb_engine #(.MODULES(MODULES)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_word(ow)
	);

	assign m_axis_tdata = {ow.end_of_frame, ow.word_data, ow.word_address,
		ow.module_slot, ow.word_valid};
	assign m_axis_tuser = ow.rejected;
	assign m_axis_tlast = ow.last;
endmodule
`default_nettype wire
